>>> sv/kmp_pkg.sv
// Shared types for the KMP stream matcher: command and status codes,
// controller states and the controller/datapath handshake structs.
// No dependencies.
package kmp_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_TEXT    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_DROP   = 2'd1,
		STS_NO_PAT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_HIT_FB,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // input transaction taken, run immediate actions
		logic step;     // one compare step of the search or table build
		logic hit_fb;   // take fallback after a full match
		logic publish;  // move finished result into output register
	} dp_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic eq;
		logic cur_zero;
		logic hit;
		logic is_text;
		logic out_free;
	} dp_stat_t;

endpackage

>>> sv/kmp_ctrl.sv
// Controller FSM for the KMP stream matcher.
// Depends on kmp_pkg; drives kmp_dp through dp_ctl_t.
module kmp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kmp_pkg::cmd_t     in_cmd,
	input  kmp_pkg::dp_stat_t stat,
	output kmp_pkg::dp_ctl_t  ctl
);
	import kmp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				ctl.accept = in_valid;
				if (in_valid) begin
					if ((in_cmd == CMD_APPEND && !stat.full && !stat.empty) ||
					    (in_cmd == CMD_TEXT && !stat.empty)) begin
						state_d = S_CMP;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_CMP: begin
				ctl.step = 1'b1;
				if (!stat.eq && !stat.cur_zero) begin
					state_d = S_CMP;
				end else if (stat.is_text && stat.eq && stat.hit) begin
					state_d = S_HIT_FB;
				end else begin
					state_d = S_DONE;
				end
			end
			S_HIT_FB: begin
				ctl.hit_fb = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					ctl.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> sv/kmp_dp.sv
// Datapath for the KMP stream matcher: pattern and fallback memories,
// match/prefix positions, text index, compare counter and output register.
// Depends on kmp_pkg; sequenced by kmp_ctrl.
module kmp_dp #(
	parameter int PATTERN_DEPTH = 64,
	parameter int POSITION_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kmp_pkg::cmd_t     in_cmd,
	input  logic [7:0]        in_byte,
	input  kmp_pkg::dp_ctl_t  ctl,
	output kmp_pkg::dp_stat_t stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [79:0]       out_data
);
	import kmp_pkg::*;

	localparam int IDX_W = $clog2(PATTERN_DEPTH);
	localparam int CNT_W = $clog2(PATTERN_DEPTH + 1);
	localparam int SUB_W = (POSITION_BITS > CNT_W) ? POSITION_BITS : CNT_W;

	logic [7:0]       pat_mem [PATTERN_DEPTH];
	logic [IDX_W-1:0] fb_mem  [PATTERN_DEPTH];

	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         prefix_q;
	logic [IDX_W-1:0]         mpos_q;
	logic [POSITION_BITS-1:0] tpos_q;
	logic [31:0]              ctotal_q;
	logic                     out_valid_q;

	cmd_t             cmd_q;
	logic [7:0]       byte_q;
	logic [7:0]       pat_rd_q;
	logic [IDX_W-1:0] fb_rd_q;
	logic             hit_q;
	logic [31:0]      start_q;
	status_t          status_q;
	logic [79:0]      out_data_q;

	logic [IDX_W-1:0]         cur;
	logic [CNT_W-1:0]         cur_inc;
	logic                     eq;
	logic                     cur_zero;
	logic                     fall;
	logic [CNT_W-1:0]         rd_addr;
	logic [CNT_W-1:0]         rd_addr_m1;
	logic [31:0]              ctotal_inc;
	logic [IDX_W-1:0]         prefix_next;
	logic [SUB_W-1:0]         start_diff;
	logic [POSITION_BITS+31:0] start_ext;
	logic [CNT_W+6:0]         len_ext;
	logic                     full;
	logic                     empty;
	logic                     mem_we;
	logic [IDX_W-1:0]         mem_wa;
	logic [IDX_W-1:0]         fb_wd;
	logic                     fb_we;

	assign cur      = (cmd_q == CMD_APPEND) ? prefix_q : mpos_q;
	assign cur_inc  = CNT_W'(cur) + CNT_W'(1);
	assign eq       = (pat_rd_q == byte_q);
	assign cur_zero = (cur == '0);
	assign fall     = !eq && !cur_zero;
	assign full     = (count_q == CNT_W'(PATTERN_DEPTH));
	assign empty    = (count_q == '0);

	assign ctotal_inc  = (ctotal_q == '1) ? ctotal_q : ctotal_q + 32'd1;
	assign prefix_next = eq ? prefix_q + IDX_W'(1) : prefix_q;
	assign start_diff  = SUB_W'(tpos_q) - SUB_W'(count_q);
	assign start_ext   = {32'd0, start_diff[POSITION_BITS-1:0]};
	assign len_ext     = {7'd0, count_q};

	assign stat.full     = full;
	assign stat.empty    = empty;
	assign stat.eq       = eq;
	assign stat.cur_zero = cur_zero;
	assign stat.hit      = (cur_inc == count_q);
	assign stat.is_text  = (cmd_q == CMD_TEXT);
	assign stat.out_free = !out_valid_q || out_ready;

	always_comb begin
		if (ctl.step) begin
			rd_addr = fall ? CNT_W'(fb_rd_q) : cur_inc;
		end else if (in_cmd == CMD_APPEND) begin
			rd_addr = CNT_W'(prefix_q);
		end else begin
			rd_addr = CNT_W'(mpos_q);
		end
		rd_addr_m1 = rd_addr - CNT_W'(1);
	end

	// pattern byte written at accept; fallback entry at accept (first byte) or end of build
	assign mem_we = ctl.accept && in_cmd == CMD_APPEND && !full;
	assign mem_wa = count_q[IDX_W-1:0];
	always_comb begin
		fb_we = 1'b0;
		fb_wd = prefix_next;
		if (mem_we && empty) begin
			fb_we = 1'b1;
			fb_wd = '0;
		end else if (ctl.step && cmd_q == CMD_APPEND && !fall) begin
			fb_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pat_mem[mem_wa] <= in_byte;
		end
		if (fb_we) begin
			fb_mem[mem_wa] <= fb_wd;
		end
		pat_rd_q <= pat_mem[rd_addr[IDX_W-1:0]];
		fb_rd_q  <= fb_mem[rd_addr_m1[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			prefix_q    <= '0;
			mpos_q      <= '0;
			tpos_q      <= '0;
			ctotal_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				unique case (in_cmd)
					CMD_CLEAR: begin
						count_q  <= '0;
						prefix_q <= '0;
						mpos_q   <= '0;
					end
					CMD_APPEND: begin
						if (!full && empty) begin
							prefix_q <= '0;
							count_q  <= CNT_W'(1);
						end
					end
					CMD_RESTART: begin
						tpos_q   <= '0;
						ctotal_q <= '0;
						mpos_q   <= '0;
					end
					CMD_TEXT: begin
						tpos_q <= tpos_q + POSITION_BITS'(1);
					end
					default: ;
				endcase
			end
			if (ctl.step) begin
				if (cmd_q == CMD_TEXT) begin
					ctotal_q <= ctotal_inc;
					if (eq) begin
						mpos_q <= cur_inc[IDX_W-1:0];
					end else if (!cur_zero) begin
						mpos_q <= fb_rd_q;
					end
				end else begin
					if (fall) begin
						prefix_q <= fb_rd_q;
					end else begin
						prefix_q <= prefix_next;
						count_q  <= count_q + CNT_W'(1);
					end
				end
			end
			if (ctl.hit_fb) begin
				mpos_q <= fb_rd_q;
			end
			if (ctl.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q    <= in_cmd;
			byte_q   <= in_byte;
			hit_q    <= 1'b0;
			start_q  <= '0;
			status_q <= STS_OK;
			if (in_cmd == CMD_APPEND && full) begin
				status_q <= STS_DROP;
			end else if (in_cmd == CMD_TEXT && empty) begin
				status_q <= STS_NO_PAT;
			end
		end
		if (ctl.step && cmd_q == CMD_TEXT && eq && stat.hit) begin
			hit_q   <= 1'b1;
			start_q <= start_ext[31:0];
		end
		if (ctl.publish) begin
			out_data_q <= {6'd0, len_ext[6:0], status_q, ctotal_q, start_q, hit_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> sv/kmp_stream_matcher_top.sv
// Top level of the KMP stream matcher: controller plus datapath.
// Depends on kmp_pkg, kmp_ctrl and kmp_dp.
//
// Usage:
//   s_axis carries commands: tuser = cmd (clear pattern, append pattern byte,
//   restart text, text byte), tdata = the byte. Every command gives exactly one
//   result on m_axis, in order.
//   m_axis tdata from bit 0: match_found, match_start[31:0],
//   comparison_count[31:0], status[1:0], loaded_length[6:0], zero pad.
// Sequencing:
//   One command at a time. Clear, restart, dropped appends, the first pattern
//   byte and text with no pattern go from accept straight to the done state,
//   which publishes the result. Appends and text bytes first run n compare
//   steps through the fallback table (one per cycle, set by the registered
//   memory read), plus a hit-fallback step after a full match to apply its
//   fallback entry, before publishing. KMP keeps n to at most two per text
//   byte on average.
// Reset clears pattern length, positions and counters; memory contents are not
//   cleared and need no clearing pass. A stalled receiver holds the result in
//   the output register; one further command is processed meanwhile and waits
//   to publish until the register frees.
module kmp_stream_matcher_top #(
	parameter int PATTERN_DEPTH = 64,
	parameter int POSITION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // match_found, match_start, comparison_count,
	                                   // status, loaded_length, pad
);
	import kmp_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;
	cmd_t     in_cmd;

	assign in_cmd = cmd_t'(s_axis_tuser);

	kmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (in_cmd),
		.stat     (stat),
		.ctl      (ctl)
	);

	kmp_dp #(
		.PATTERN_DEPTH (PATTERN_DEPTH),
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (in_cmd),
		.in_byte   (s_axis_tdata),
		.ctl       (ctl),
		.stat      (stat),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule
